// File: src/sitda_pkg.sv
// sitda_pkg: shared types and constants for the signed integer to decimal ascii block
// used by sitda_cell and signed_int_to_decimal_ascii, depends on nothing
package sitda_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGIT_W         = 4;
    localparam int BITS_PER_STEP   = 4;
    localparam int CONV_STEPS      = VALUE_W / BITS_PER_STEP;
    localparam int DIGIT_SLOTS_DEF = 10;

    localparam logic [7:0]         ASCII_ZERO  = 8'd48;
    localparam logic [7:0]         ASCII_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT   = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: src/sitda_cell.sv
// sitda_cell: one decimal digit of the conversion chain
// shift-add-3 on four bits per cycle, hands its digit to the next cell, or clears to zero; uses sitda_pkg
module sitda_cell
    import sitda_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [BITS_PER_STEP-1:0] bits_in,
    output logic [BITS_PER_STEP-1:0] bits_out,
    input  logic [DIGIT_W-1:0]       digit_in,
    output logic [DIGIT_W-1:0]       digit_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] conv_digit;

    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        d = digit_reg;
        bits_out = '0;
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            if (d >= ADJ_LIMIT)
            begin
                d = d + ADJ_ADD;
            end
            bits_out[BITS_PER_STEP-1-j] = d[DIGIT_W-1];
            d = {d[DIGIT_W-2:0], bits_in[BITS_PER_STEP-1-j]};
        end
        conv_digit = d;
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.conv)
        begin
            digit_next = conv_digit;
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit_out = digit_reg;

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, sequencer, magnitude register and output register
// builds a chain of sitda_cell digits; uses sitda_pkg
//
// input channel: value with in_valid / in_stall, one signed integer per request
// output channel: char_code and last with out_valid / out_stall, one ascii character
//   per request, most significant first, last set on the final character of a run
// a request is taken only while the block is idle; in_stall stays high until the
//   final character of the run has been loaded into the output register
// conversion: the magnitude enters the digit chain four bits per cycle
// leading zeros: shifted out of the top cell one at a time until the top digit is
//   nonzero (DIGIT_SLOTS - digit count zeros, none when the value has more digits
//   than the chain)
// then one character per cycle while the receiver takes them
// states per integer: ST_IDLE accepts, then ST_CONV, ST_SKIP and ST_EMIT in that order;
//   the default chain has 10 digit cells
// out_stall holds the output register and, in the emit state, the sequencer; nothing is lost or repeated
// reset: asynchronous, active low; returns to idle with no character pending
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                char_code,
    output logic                      last
);

    localparam int LEFT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int STEP_W = $clog2(CONV_STEPS);

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                ovf_reg, ovf_next;
    logic                sign_reg, sign_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;

    cell_ctrl_t          ctrl;
    logic [BITS_PER_STEP-1:0] bits_link  [0:DIGIT_SLOTS];
    logic [DIGIT_W-1:0]       digit_link [0:DIGIT_SLOTS];
    logic [DIGIT_W-1:0]  top_digit;
    logic                accept;
    logic                out_free;

    assign bits_link[0]  = mag_reg[VALUE_W-1 -: BITS_PER_STEP];
    assign digit_link[0] = '0;
    assign top_digit     = digit_link[DIGIT_SLOTS];

    for (genvar i = 0; i < DIGIT_SLOTS; i++)
    begin : g_cell
        sitda_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .bits_in   (bits_link[i]),
            .bits_out  (bits_link[i+1]),
            .digit_in  (digit_link[i]),
            .digit_out (digit_link[i+1])
        );
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        ovf_next       = ovf_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sign_next  = value[VALUE_W-1];
                    mag_next   = value[VALUE_W-1] ? (~value + 1'b1) : value;
                    step_next  = '0;
                    left_next  = LEFT_W'(DIGIT_SLOTS);
                    ovf_next   = 1'b0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.conv = 1'b1;
                mag_next  = mag_reg << BITS_PER_STEP;
                ovf_next  = ovf_reg || (|bits_link[DIGIT_SLOTS]);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == '0 && !ovf_reg && left_reg != LEFT_W'(1))
                begin
                    ctrl.shift = 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = ASCII_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next  = ASCII_ZERO + 8'(top_digit);
                        last_next  = (left_reg == LEFT_W'(1));
                        ctrl.shift = 1'b1;
                        left_next  = left_reg - 1'b1;
                        if (left_reg == LEFT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        step_reg <= step_next;
        left_reg <= left_next;
        ovf_reg  <= ovf_next;
        sign_reg <= sign_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule
